@@ rtl/core/kls_pkg.sv @@
package kls_pkg;

  localparam int STACK_DEPTH   = 8;
  localparam int NUM_MODIFIERS = 4;
  localparam int NUM_LAYERS    = 16;
  localparam int NUM_KEYS      = 256;
  localparam int NUM_EVENTS    = 3;

  localparam int PTR_W   = $clog2(STACK_DEPTH);
  localparam int LAYER_W = $clog2(NUM_LAYERS);
  localparam int KEY_W   = $clog2(NUM_KEYS);
  localparam int MOD_W   = $clog2(NUM_MODIFIERS);
  localparam int EV_W    = 2;
  localparam int CODE_W  = 16;
  localparam int CNT_W   = 4;
  localparam int MAP_W   = MOD_W + 1;

  localparam int BIND_DEPTH = NUM_LAYERS * NUM_KEYS * NUM_EVENTS;
  localparam int BIND_AW    = $clog2(BIND_DEPTH);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    ACT_KEY    = 3'd0,
    ACT_PUSH   = 3'd1,
    ACT_POP    = 3'd2,
    ACT_POPIF  = 3'd3,
    ACT_BIND   = 3'd4,
    ACT_MODKEY = 3'd5,
    ACT_QUERY  = 3'd6,
    ACT_SPARE  = 3'd7
  } action_t;

  localparam logic [EV_W-1:0] EV_UP   = 2'd0;
  localparam logic [EV_W-1:0] EV_DOWN = 2'd1;
  localparam logic [EV_W-1:0] EV_HOLD = 2'd2;
  // Event code beyond hold: no lookup, no modifier change, bind ignored.
  localparam logic [EV_W-1:0] EV_NONE = 2'd3;

  // Binding table entries are ordered layer, then key, then event.
  function automatic logic [BIND_AW-1:0] bind_addr(
    input logic [LAYER_W-1:0] l,
    input logic [KEY_W-1:0]   k,
    input logic [EV_W-1:0]    e
  );
    logic [BIND_AW-1:0] lk;
    lk = BIND_AW'({l, k});
    return (lk << 1) + lk + BIND_AW'(e);
  endfunction

endpackage

@@ rtl/core/kls_ram.sv @@
module kls_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/keymap_layer_stack_resolver.sv @@
// Channel   Ports                                             Handshake
// command   action key_code key_event layer binding_code      start, busy
//           modifier_index modifier_valid
// result    found action_code matched_layer top_layer         done (one cycle)
//           stack_level modifier_mask status
//
// After reset the block sweeps the binding table and the modifier key map,
// one entry a cycle with busy high, before it takes a word.
// Stack edits, table writes and queries go from execution straight to done.
// A key event walks k stack levels (1 to 8) from the top down, each level
// costing one read of the binding memory, then updates the modifiers.
// A key event with event code 3 skips the walk and the modifier update.
// The receiver cannot stall: done is high for exactly one cycle per word.
module keymap_layer_stack_resolver (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   action,
  input  logic [kls_pkg::KEY_W-1:0]    key_code,
  input  logic [kls_pkg::EV_W-1:0]     key_event,
  input  logic [kls_pkg::LAYER_W-1:0]  layer,
  input  logic [kls_pkg::CODE_W-1:0]   binding_code,
  input  logic [kls_pkg::MOD_W-1:0]    modifier_index,
  input  logic                         modifier_valid,
  output logic                         done,
  output logic                         found,
  output logic [kls_pkg::CODE_W-1:0]   action_code,
  output logic [kls_pkg::LAYER_W-1:0]  matched_layer,
  output logic [kls_pkg::LAYER_W-1:0]  top_layer,
  output logic [kls_pkg::PTR_W-1:0]    stack_level,
  output logic [kls_pkg::LAYER_W-1:0]  modifier_mask,
  output logic                         status
);

  import kls_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR    = 7'b0000001,
    S_IDLE     = 7'b0000010,
    S_EXEC     = 7'b0000100,
    S_WALK_RD  = 7'b0001000,
    S_WALK_CHK = 7'b0010000,
    S_MOD      = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t state;

  logic [BIND_AW-1:0] clr_cnt;

  // Latched command word.
  action_t            act;
  logic [KEY_W-1:0]   key;
  logic [EV_W-1:0]    ev;
  logic [LAYER_W-1:0] lay;
  logic [CODE_W-1:0]  code;
  logic [MOD_W-1:0]   midx;
  logic               mval;

  // Entry 0 of the stack is the modifier mask, which also serves as the root layer.
  logic [LAYER_W-1:0] stk [STACK_DEPTH];
  logic [PTR_W-1:0]   top;
  logic [PTR_W-1:0]   walk_ptr;
  logic [LAYER_W-1:0] walk_layer;
  logic [CNT_W-1:0]   cnt [NUM_MODIFIERS];

  logic [PTR_W-1:0]   rd_ptr;
  logic [LAYER_W-1:0] rd_val;

  logic               bind_we;
  logic [BIND_AW-1:0] bind_waddr;
  logic [CODE_W-1:0]  bind_wdata;
  logic               bind_re;
  logic [BIND_AW-1:0] bind_raddr;
  logic [CODE_W-1:0]  bind_rdata;

  logic               map_we;
  logic [KEY_W-1:0]   map_waddr;
  logic [MAP_W-1:0]   map_wdata;
  logic               map_re;
  logic [MAP_W-1:0]   map_rdata;

  logic [MOD_W-1:0]   mod_sel;
  logic [LAYER_W-1:0] mod_bit;
  logic [CNT_W-1:0]   cnt_dec;

  logic               clearing;
  logic               exec_bind;
  logic               exec_map;

  // The stack is read at one place a cycle: the walk position or the top.
  assign rd_ptr = (state == S_WALK_RD) ? walk_ptr : top;
  assign rd_val = stk[rd_ptr];

  assign clearing  = (state == S_CLEAR);
  assign exec_bind = (state == S_EXEC) && (act == ACT_BIND) && (ev != EV_NONE);
  assign exec_map  = (state == S_EXEC) && (act == ACT_MODKEY);

  assign bind_we    = clearing || exec_bind;
  assign bind_waddr = clearing ? clr_cnt : bind_addr(lay, key, ev);
  assign bind_wdata = clearing ? '0 : code;
  assign bind_re    = (state == S_WALK_RD);
  assign bind_raddr = bind_addr(rd_val, key, ev);

  assign map_we    = (clearing && (clr_cnt < BIND_AW'(NUM_KEYS))) || exec_map;
  assign map_waddr = clearing ? clr_cnt[KEY_W-1:0] : key;
  assign map_wdata = (!clearing && mval) ? {1'b1, midx} : '0;
  assign map_re    = (state == S_EXEC) && (act == ACT_KEY);

  assign mod_sel = map_rdata[MOD_W-1:0];
  assign mod_bit = LAYER_W'(1) << mod_sel;
  assign cnt_dec = (cnt[mod_sel] == '0) ? '0 : cnt[mod_sel] - CNT_W'(1);

  kls_ram #(.WIDTH(CODE_W), .DEPTH(BIND_DEPTH)) u_bind_ram (
    .clk   (clk),
    .we    (bind_we),
    .waddr (bind_waddr),
    .wdata (bind_wdata),
    .re    (bind_re),
    .raddr (bind_raddr),
    .rdata (bind_rdata)
  );

  kls_ram #(.WIDTH(MAP_W), .DEPTH(NUM_KEYS)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (key),
    .rdata (map_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      top     <= '0;
      status  <= 1'b0;
      for (int i = 0; i < STACK_DEPTH; i++) begin
        stk[i] <= '0;
      end
      for (int i = 0; i < NUM_MODIFIERS; i++) begin
        cnt[i] <= '0;
      end
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + BIND_AW'(1);
          if (clr_cnt == BIND_AW'(BIND_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            act   <= action_t'(action);
            key   <= key_code;
            ev    <= key_event;
            lay   <= layer;
            code  <= binding_code;
            midx  <= modifier_index;
            mval  <= modifier_valid;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          found         <= 1'b0;
          action_code   <= '0;
          matched_layer <= '0;
          status        <= (act == ACT_PUSH) && (top == PTR_W'(STACK_DEPTH - 1));
          walk_ptr      <= top;
          state         <= ((act == ACT_KEY) && (ev != EV_NONE)) ? S_WALK_RD : S_DONE;
          case (act)
            ACT_PUSH: begin
              if (top != PTR_W'(STACK_DEPTH - 1)) begin
                top                      <= top + PTR_W'(1);
                stk[top + PTR_W'(1)]     <= lay;
              end
            end
            ACT_POP: begin
              if (top != '0) begin
                top <= top - PTR_W'(1);
              end
            end
            ACT_POPIF: begin
              if ((rd_val == lay) && (top != '0)) begin
                top <= top - PTR_W'(1);
              end
            end
            default: begin
            end
          endcase
        end
        S_WALK_RD: begin
          walk_layer <= rd_val;
          state      <= S_WALK_CHK;
        end
        S_WALK_CHK: begin
          if (bind_rdata != '0) begin
            found         <= 1'b1;
            action_code   <= bind_rdata;
            matched_layer <= walk_layer;
            state         <= S_MOD;
          end else if (walk_ptr == '0) begin
            state <= S_MOD;
          end else begin
            walk_ptr <= walk_ptr - PTR_W'(1);
            state    <= S_WALK_RD;
          end
        end
        S_MOD: begin
          // Hold events only look up; up and down events of modifier keys count.
          if (map_rdata[MAP_W-1] && (ev != EV_HOLD)) begin
            if (ev == EV_DOWN) begin
              if (cnt[mod_sel] != CNT_MAX) begin
                cnt[mod_sel] <= cnt[mod_sel] + CNT_W'(1);
              end
              stk[0] <= stk[0] | mod_bit;
            end else begin
              cnt[mod_sel] <= cnt_dec;
              if (cnt_dec == '0) begin
                stk[0] <= stk[0] & ~mod_bit;
              end
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state != S_IDLE);
  assign done          = (state == S_DONE);
  assign top_layer     = rd_val;
  assign stack_level   = top;
  assign modifier_mask = stk[0];

endmodule
